### rtl/i2cra_pkg.sv
// Shared types and constants for the I2C register access master.
// Holds phase codes, request codes and the result record.
// No dependencies.
package i2cra_pkg;

  // request codes carried on the action field
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;  // no step, no latch

  // bus sequencer phases
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_SDA = 5'd1;
  localparam logic [4:0] PH_START_SCL = 5'd2;
  localparam logic [4:0] PH_BIT_SDA   = 5'd3;
  localparam logic [4:0] PH_BIT_SCLH  = 5'd4;
  localparam logic [4:0] PH_BIT_SCLL  = 5'd5;
  localparam logic [4:0] PH_ACK_SDA   = 5'd6;
  localparam logic [4:0] PH_ACK_SCLH  = 5'd7;
  localparam logic [4:0] PH_ACK_SMP   = 5'd8;
  localparam logic [4:0] PH_ACK_SDA0  = 5'd9;
  localparam logic [4:0] PH_RS_SDA1   = 5'd10;
  localparam logic [4:0] PH_RS_SCL1   = 5'd11;
  localparam logic [4:0] PH_RS_SDA0   = 5'd12;
  localparam logic [4:0] PH_RS_SCL0   = 5'd13;
  localparam logic [4:0] PH_GB_SCL0   = 5'd14;
  localparam logic [4:0] PH_GB_SCLH   = 5'd15;
  localparam logic [4:0] PH_GB_SMP    = 5'd16;
  localparam logic [4:0] PH_GB_SDA1   = 5'd17;
  localparam logic [4:0] PH_STOP_SDA0 = 5'd18;
  localparam logic [4:0] PH_STOP_SCL1 = 5'd19;
  localparam logic [4:0] PH_STOP_SDA1 = 5'd20;

  // byte slots in a transaction
  localparam logic [1:0] BYTE_ADDR = 2'd0;
  localparam logic [1:0] BYTE_REG  = 2'd1;
  localparam logic [1:0] BYTE_LAST = 2'd2;

  // configuration register index and reset value
  localparam logic       REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [6:0] DEV_ADDR_RESET     = 7'd72;

  // one result record
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

### rtl/i2c_register_access_master.sv
// I2C register access master: at most one pin step per accepted request.
// A result is registered in the output register, or in the skid entry.
// Throughput: one request per cycle while the skid entry is empty; the skid
// entry lets a request be taken while the current result waits.
// Reset (rst_n, synchronous): bus released, sequencer idle, address 72.
// Depends on i2cra_pkg.
module i2c_register_access_master
  import i2cra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic       in_sda_in,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_nack_error,
  output logic [7:0] out_read_data,
  output logic       out_rejected,
  // configuration port
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  // configuration register
  logic [6:0] dev_addr_r;

  // sequencer state
  logic [4:0] phase_r,     phase_nxt;
  logic [3:0] bit_cnt_r,   bit_cnt_nxt;
  logic [7:0] shift_r,     shift_nxt;
  logic [1:0] byte_idx_r,  byte_idx_nxt;
  logic       is_read_r,   is_read_nxt;
  logic [7:0] held_reg_r,  held_reg_nxt;
  logic [7:0] held_data_r, held_data_nxt;
  logic       scl_r,       scl_nxt;
  logic       sda_r,       sda_nxt;
  logic       nack_r,      nack_nxt;

  // output register and skid entry
  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;
  res_t res;

  logic in_accept;
  logic out_pop;
  logic cfg_wr;
  logic [3:0] bit_inc;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign out_pop   = out_valid_r && !out_stall;
  assign bit_inc   = bit_cnt_r + 4'd1;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DEVICE_ADDRESS);
  assign prdata = (paddr[2] == REG_DEVICE_ADDRESS) ? {25'd0, dev_addr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else if (cfg_wr) begin
      dev_addr_r <= pwdata[6:0];
    end
  end

  // byte to shift out for a given slot
  function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [6:0] dev,
                                          input logic [7:0] hreg, input logic [7:0] hdata,
                                          input logic rd);
    logic [7:0] b;
    begin
      if (idx == BYTE_ADDR) begin
        b = {dev, 1'b0};
      end else if (idx == BYTE_REG) begin
        b = hreg;
      end else if (rd) begin
        b = {dev, 1'b1};
      end else begin
        b = hdata;
      end
      return b;
    end
  endfunction

  // one pin step
  always_comb begin
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    byte_idx_nxt  = byte_idx_r;
    is_read_nxt   = is_read_r;
    held_reg_nxt  = held_reg_r;
    held_data_nxt = held_data_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    nack_nxt      = nack_r;
    res           = '0;

    if (in_action == ACT_WRITE || in_action == ACT_READ) begin
      if (phase_r != PH_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        held_reg_nxt  = in_reg_addr;
        held_data_nxt = in_write_data;
        is_read_nxt   = (in_action == ACT_READ);
        nack_nxt      = 1'b0;
        bit_cnt_nxt   = 4'd0;
        byte_idx_nxt  = BYTE_ADDR;
        shift_nxt     = 8'd0;
        phase_nxt     = PH_START_SDA;
      end
    end else if (in_action == ACT_TICK) begin
      case (phase_r)
        PH_START_SDA: begin
          sda_nxt = 1'b0; phase_nxt = PH_START_SCL;
        end
        PH_START_SCL: begin
          scl_nxt = 1'b0;
          byte_idx_nxt = BYTE_ADDR;
          bit_cnt_nxt = 4'd0;
          shift_nxt = byte_for(BYTE_ADDR, dev_addr_r, held_reg_r, held_data_r, is_read_r);
          phase_nxt = PH_BIT_SDA;
        end
        PH_BIT_SDA: begin
          sda_nxt = shift_r[7]; phase_nxt = PH_BIT_SCLH;
        end
        PH_BIT_SCLH: begin
          scl_nxt = 1'b1; phase_nxt = PH_BIT_SCLL;
        end
        PH_BIT_SCLL: begin
          scl_nxt     = 1'b0;
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bit_inc;
          phase_nxt   = (bit_inc >= 4'd8) ? PH_ACK_SDA : PH_BIT_SDA;
        end
        PH_ACK_SDA: begin
          sda_nxt = 1'b1; phase_nxt = PH_ACK_SCLH;
        end
        PH_ACK_SCLH: begin
          scl_nxt = 1'b1; phase_nxt = PH_ACK_SMP;
        end
        PH_ACK_SMP: begin
          nack_nxt = in_sda_in; scl_nxt = 1'b0; phase_nxt = PH_ACK_SDA0;
        end
        PH_ACK_SDA0: begin
          sda_nxt = 1'b0;
          if (nack_r) begin
            phase_nxt = PH_STOP_SDA0;
          end else if (byte_idx_r == BYTE_ADDR) begin
            byte_idx_nxt = BYTE_REG;
            bit_cnt_nxt  = 4'd0;
            shift_nxt    = byte_for(BYTE_REG, dev_addr_r, held_reg_r, held_data_r, is_read_r);
            phase_nxt    = PH_BIT_SDA;
          end else if (byte_idx_r == BYTE_REG) begin
            if (is_read_r) begin
              phase_nxt = PH_RS_SDA1;
            end else begin
              byte_idx_nxt = BYTE_LAST;
              bit_cnt_nxt  = 4'd0;
              shift_nxt    = byte_for(BYTE_LAST, dev_addr_r, held_reg_r, held_data_r,
                                      is_read_r);
              phase_nxt    = PH_BIT_SDA;
            end
          end else begin
            phase_nxt = is_read_r ? PH_GB_SCL0 : PH_STOP_SDA0;
          end
        end
        PH_RS_SDA1: begin
          sda_nxt = 1'b1; phase_nxt = PH_RS_SCL1;
        end
        PH_RS_SCL1: begin
          scl_nxt = 1'b1; phase_nxt = PH_RS_SDA0;
        end
        PH_RS_SDA0: begin
          sda_nxt = 1'b0; phase_nxt = PH_RS_SCL0;
        end
        PH_RS_SCL0: begin
          scl_nxt      = 1'b0;
          byte_idx_nxt = BYTE_LAST;
          bit_cnt_nxt  = 4'd0;
          shift_nxt    = byte_for(BYTE_LAST, dev_addr_r, held_reg_r, held_data_r, is_read_r);
          phase_nxt    = PH_BIT_SDA;
        end
        PH_GB_SCL0: begin
          scl_nxt = 1'b0; shift_nxt = 8'd0; bit_cnt_nxt = 4'd0; phase_nxt = PH_GB_SCLH;
        end
        PH_GB_SCLH: begin
          scl_nxt = 1'b1; phase_nxt = PH_GB_SMP;
        end
        PH_GB_SMP: begin
          shift_nxt   = {shift_r[6:0], in_sda_in};
          scl_nxt     = 1'b0;
          bit_cnt_nxt = bit_inc;
          phase_nxt   = (bit_inc >= 4'd8) ? PH_GB_SDA1 : PH_GB_SCLH;
        end
        PH_GB_SDA1: begin
          sda_nxt = 1'b1; phase_nxt = PH_STOP_SDA0;
        end
        PH_STOP_SDA0: begin
          sda_nxt = 1'b0; phase_nxt = PH_STOP_SCL1;
        end
        PH_STOP_SCL1: begin
          scl_nxt = 1'b1; phase_nxt = PH_STOP_SDA1;
        end
        PH_STOP_SDA1: begin
          sda_nxt        = 1'b1;
          res.done_res   = 1'b1;
          res.nack_error = nack_r;
          res.read_data  = (is_read_r && !nack_r) ? shift_r : 8'd0;
          phase_nxt      = PH_IDLE;
        end
        default: begin
          // idle or an unused code: no step
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  // sequencer state update on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= 4'd0;
      shift_r     <= 8'd0;
      byte_idx_r  <= BYTE_ADDR;
      is_read_r   <= 1'b0;
      held_reg_r  <= 8'd0;
      held_data_r <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      nack_r      <= 1'b0;
    end else if (in_accept) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      shift_r     <= shift_nxt;
      byte_idx_r  <= byte_idx_nxt;
      is_read_r   <= is_read_nxt;
      held_reg_r  <= held_reg_nxt;
      held_data_r <= held_data_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      nack_r      <= nack_nxt;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (in_accept) begin
      if (!out_valid_r || out_pop) begin
        out_res_r <= res;
      end else begin
        skid_res_r <= res;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = out_res_r.scl_level;
  assign out_sda_level  = out_res_r.sda_level;
  assign out_busy_res   = out_res_r.busy_res;
  assign out_done_res   = out_res_r.done_res;
  assign out_nack_error = out_res_r.nack_error;
  assign out_read_data  = out_res_r.read_data;
  assign out_rejected   = out_res_r.rejected;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res) |-> !out_res_r.busy_res)
    else $error("done reported while still busy");

  a_done_bus_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res) |-> (out_res_r.scl_level && out_res_r.sda_level))
    else $error("stop did not leave the bus released");

  a_flags_need_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.done_res) |->
      (!out_res_r.nack_error && out_res_r.read_data == 8'd0))
    else $error("error or read data without done");

  a_reject_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.rejected) |-> (!out_res_r.done_res && out_res_r.busy_res))
    else $error("rejected request changed the transaction");

endmodule
